@@ sv/erg_pkg.sv @@
// ----------------------------------------------------------------------------
// erg_pkg: shared definitions for the elliptical radial gradient fill
// Widths, register indexes and the structs passed between pipeline sections.
// ----------------------------------------------------------------------------
package erg_pkg;

  // Coordinate width and fraction bits of the fade value.
  localparam int unsigned CoordBits    = 12;
  localparam int unsigned FadeFracBits = 16;

  // Fade values are unsigned Q1.F, so one integer bit on top of the fraction.
  localparam int unsigned FadeBits = FadeFracBits + 1;
  // Sum of two squared Q1.F values.
  localparam int unsigned SqBits   = 2 * FadeBits;
  // Partial remainder of the digit-by-digit square root.
  localparam int unsigned RemBits  = FadeBits + 2;
  // Signed blend product: 9-bit difference times a signed fade.
  localparam int unsigned ProdBits = FadeBits + 10;

  // Configuration port.
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = (CoordBits > 8) ? CoordBits : 8;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned InDataBits  = ((2 * CoordBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = ((2 * CoordBits + 24 + 7) / 8) * 8;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxBits-1:0] {
    REG_SPAN_X      = 3'd0,
    REG_SPAN_Y      = 3'd1,
    REG_START_RED   = 3'd2,
    REG_START_GREEN = 3'd3,
    REG_START_BLUE  = 3'd4,
    REG_END_RED     = 3'd5,
    REG_END_GREEN   = 3'd6,
    REG_END_BLUE    = 3'd7
  } cfg_reg_e;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [7:0]           chan_t;
  typedef logic [FadeBits-1:0]  fade_t;

  localparam fade_t FadeOne = fade_t'(1) << FadeFracBits;

  // Current configuration, held stable by the user while items are in flight.
  typedef struct packed {
    coord_t span_x;
    coord_t span_y;
    chan_t  start_red;
    chan_t  start_green;
    chan_t  start_blue;
    chan_t  end_red;
    chan_t  end_green;
    chan_t  end_blue;
  } cfg_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
  } pos_t;

  // Normalized axis distances, saturated to one.
  typedef struct packed {
    pos_t  pos;
    fade_t qx;
    fade_t qy;
  } norm_t;

  // Unclamped radial distance.
  typedef struct packed {
    pos_t  pos;
    fade_t radius;
  } shade_t;

  // Finished pixel.
  typedef struct packed {
    pos_t  pos;
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

endpackage

@@ sv/erg_cfg.sv @@
// ----------------------------------------------------------------------------
// erg_cfg: configuration register file
// Holds the rectangle spans and the two gradient colors.
// ----------------------------------------------------------------------------
module erg_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [erg_pkg::CfgIdxBits-1:0]  idx_i,
  input  logic [erg_pkg::CfgDataBits-1:0] data_i,
  output erg_pkg::cfg_t                   cfg_o
);

  erg_pkg::cfg_t cfg_q, cfg_d;
  erg_pkg::chan_t wr_chan;
  erg_pkg::coord_t wr_coord;

  assign wr_chan  = data_i[7:0];
  assign wr_coord = data_i[erg_pkg::CoordBits-1:0];

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (erg_pkg::cfg_reg_e'(idx_i))
        erg_pkg::REG_SPAN_X:      cfg_d.span_x      = wr_coord;
        erg_pkg::REG_SPAN_Y:      cfg_d.span_y      = wr_coord;
        erg_pkg::REG_START_RED:   cfg_d.start_red   = wr_chan;
        erg_pkg::REG_START_GREEN: cfg_d.start_green = wr_chan;
        erg_pkg::REG_START_BLUE:  cfg_d.start_blue  = wr_chan;
        erg_pkg::REG_END_RED:     cfg_d.end_red     = wr_chan;
        erg_pkg::REG_END_GREEN:   cfg_d.end_green   = wr_chan;
        erg_pkg::REG_END_BLUE:    cfg_d.end_blue    = wr_chan;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // Registers with their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.span_x      <= erg_pkg::coord_t'(1);
      cfg_q.span_y      <= erg_pkg::coord_t'(1);
      cfg_q.start_red   <= 8'd0;
      cfg_q.start_green <= 8'd0;
      cfg_q.start_blue  <= 8'd0;
      cfg_q.end_red     <= 8'd255;
      cfg_q.end_green   <= 8'd255;
      cfg_q.end_blue    <= 8'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/erg_norm.sv @@
// ----------------------------------------------------------------------------
// erg_norm: axis normalization pipeline
// Folds each offset about the rectangle center and divides it by the span,
// one quotient bit per stage, for both axes side by side.
// ----------------------------------------------------------------------------
module erg_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  erg_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  erg_pkg::pos_t  pos_i,
  output logic           valid_o,
  output erg_pkg::norm_t norm_o
);

  localparam int unsigned Stages = erg_pkg::FadeFracBits + 1;

  // Division state of one axis: saturation flag, partial remainder, quotient.
  typedef struct packed {
    logic                              sat;
    erg_pkg::coord_t                   rem;
    logic [erg_pkg::FadeFracBits-1:0]  quo;
  } div_t;

  // Fold the offset about the center and detect a distance of one or more.
  function automatic div_t div_init(erg_pkg::coord_t off, erg_pkg::coord_t span_raw,
                                    erg_pkg::coord_t span_eff);
    logic [erg_pkg::CoordBits:0] twice;
    logic [erg_pkg::CoordBits:0] span_w;
    logic [erg_pkg::CoordBits:0] fold;
    div_t                        d;
    twice  = {off, 1'b0};
    span_w = {1'b0, span_raw};
    fold   = (twice >= span_w) ? (twice - span_w) : (span_w - twice);
    d.sat  = (fold >= {1'b0, span_eff});
    d.rem  = d.sat ? '0 : fold[erg_pkg::CoordBits-1:0];
    d.quo  = '0;
    return d;
  endfunction

  // One restoring division step: shift the remainder, subtract if it fits.
  function automatic div_t div_step(div_t d, erg_pkg::coord_t span_eff);
    logic [erg_pkg::CoordBits:0] r2;
    logic [erg_pkg::CoordBits:0] diff;
    logic                        ge;
    div_t                        n;
    r2    = {d.rem, 1'b0};
    diff  = r2 - {1'b0, span_eff};
    ge    = (r2 >= {1'b0, span_eff});
    n.sat = d.sat;
    n.rem = ge ? diff[erg_pkg::CoordBits-1:0] : r2[erg_pkg::CoordBits-1:0];
    n.quo = {d.quo[erg_pkg::FadeFracBits-2:0], ge};
    return n;
  endfunction

  erg_pkg::coord_t span_x_eff, span_y_eff;
  div_t            x_q   [Stages];
  div_t            y_q   [Stages];
  erg_pkg::pos_t   pos_q [Stages];
  logic            v_q   [Stages];

  // A zero span behaves as a span of one.
  assign span_x_eff = (cfg_i.span_x == '0) ? erg_pkg::coord_t'(1) : cfg_i.span_x;
  assign span_y_eff = (cfg_i.span_y == '0) ? erg_pkg::coord_t'(1) : cfg_i.span_y;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < Stages; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // First stage: fold about the center.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= div_init(pos_i.col, cfg_i.span_x, span_x_eff);
      y_q[0]   <= div_init(pos_i.row, cfg_i.span_y, span_y_eff);
      pos_q[0] <= pos_i;
    end
  end

  // Division stages, one quotient bit each.
  for (genvar k = 1; k < Stages; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= div_step(x_q[k-1], span_x_eff);
        y_q[k]   <= div_step(y_q[k-1], span_y_eff);
        pos_q[k] <= pos_q[k-1];
      end
    end
  end

  // Saturated distances go out as exactly one.
  assign valid_o    = v_q[Stages-1];
  assign norm_o.pos = pos_q[Stages-1];
  assign norm_o.qx  = x_q[Stages-1].sat ? erg_pkg::FadeOne : {1'b0, x_q[Stages-1].quo};
  assign norm_o.qy  = y_q[Stages-1].sat ? erg_pkg::FadeOne : {1'b0, y_q[Stages-1].quo};

endmodule

@@ sv/erg_sqrt.sv @@
// ----------------------------------------------------------------------------
// erg_sqrt: radial distance pipeline
// Squares both normalized axes, adds them and takes the integer square root,
// one root bit per stage.
// ----------------------------------------------------------------------------
module erg_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  erg_pkg::norm_t  norm_i,
  output logic            valid_o,
  output erg_pkg::shade_t shade_o
);

  // Square stage, sum stage, then one stage per root bit.
  localparam int unsigned RootStages = erg_pkg::FadeBits + 1;
  localparam int unsigned Stages     = RootStages + 1;

  typedef struct packed {
    logic [erg_pkg::SqBits-1:0]  rad;
    logic [erg_pkg::RemBits-1:0] rem;
    erg_pkg::fade_t              root;
  } root_t;

  // One digit-by-digit step: bring down two radicand bits, try root*4+1.
  function automatic root_t root_step(root_t r);
    logic [erg_pkg::RemBits-1:0] cat;
    logic [erg_pkg::RemBits-1:0] trial;
    logic                        ge;
    root_t                       n;
    cat    = {r.rem[erg_pkg::FadeBits-1:0], r.rad[erg_pkg::SqBits-1 -: 2]};
    trial  = {r.root, 2'b01};
    ge     = (cat >= trial);
    n.rem  = ge ? (cat - trial) : cat;
    n.root = {r.root[erg_pkg::FadeBits-2:0], ge};
    n.rad  = {r.rad[erg_pkg::SqBits-3:0], 2'b00};
    return n;
  endfunction

  logic [erg_pkg::SqBits-1:0] sq_x_q, sq_y_q;
  erg_pkg::pos_t              sq_pos_q;
  root_t                      rt_q  [RootStages];
  erg_pkg::pos_t              pos_q [RootStages];
  logic                       v_q   [Stages];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < Stages; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // Square both axes.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q   <= erg_pkg::SqBits'(norm_i.qx) * erg_pkg::SqBits'(norm_i.qx);
      sq_y_q   <= erg_pkg::SqBits'(norm_i.qy) * erg_pkg::SqBits'(norm_i.qy);
      sq_pos_q <= norm_i.pos;
    end
  end

  // Sum of squares starts the root iteration.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_q[0].rad  <= sq_x_q + sq_y_q;
      rt_q[0].rem  <= '0;
      rt_q[0].root <= '0;
      pos_q[0]     <= sq_pos_q;
    end
  end

  // Root stages, one result bit each.
  for (genvar k = 1; k < RootStages; k++) begin : g_root
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[k]  <= root_step(rt_q[k-1]);
        pos_q[k] <= pos_q[k-1];
      end
    end
  end

  assign valid_o        = v_q[Stages-1];
  assign shade_o.pos    = pos_q[RootStages-1];
  assign shade_o.radius = rt_q[RootStages-1].root;

endmodule

@@ sv/erg_blend.sv @@
// ----------------------------------------------------------------------------
// erg_blend: color interpolation and output stage
// Clamps the fade, blends the two colors per channel, and holds results in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
module erg_blend (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  erg_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  erg_pkg::shade_t shade_i,
  output logic            ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output erg_pkg::pix_t   pix_o
);

  typedef logic signed [erg_pkg::ProdBits-1:0] prod_t;

  // Fixed-point interpolation tail: start * 2^F + product, floored.
  function automatic erg_pkg::chan_t blend_fin(erg_pkg::chan_t start, prod_t prod);
    prod_t sum;
    sum = prod + prod_t'({start, {erg_pkg::FadeFracBits{1'b0}}});
    return sum[erg_pkg::ProdBits-1] ? 8'd0
                                    : sum[erg_pkg::FadeFracBits +: 8];
  endfunction

  logic                                 en;
  erg_pkg::fade_t                       fade;
  logic signed [erg_pkg::FadeBits:0]    fade_s;
  erg_pkg::chan_t                       from_c [3];
  erg_pkg::chan_t                       to_c   [3];
  prod_t                                prod   [3];
  prod_t                                prod_q [3];
  erg_pkg::pos_t                        p0_pos_q;
  logic                                 p0_v_q;
  erg_pkg::pix_t                        p1_q;
  logic                                 p1_v_q;
  erg_pkg::pix_t                        out_q;
  logic                                 out_v_q;
  erg_pkg::pix_t                        skid_q;
  logic                                 skid_v_q;
  logic                                 out_free;

  // The pipeline moves while the skid register is empty.
  assign en      = !skid_v_q;
  assign ready_o = en;

  // Clamp the distance to one.
  assign fade   = (shade_i.radius > erg_pkg::FadeOne) ? erg_pkg::FadeOne : shade_i.radius;
  assign fade_s = $signed({1'b0, fade});

  assign from_c[0] = cfg_i.start_red;
  assign from_c[1] = cfg_i.start_green;
  assign from_c[2] = cfg_i.start_blue;
  assign to_c[0]   = cfg_i.end_red;
  assign to_c[1]   = cfg_i.end_green;
  assign to_c[2]   = cfg_i.end_blue;

  // Color difference times fade, one multiplier per channel.
  for (genvar c = 0; c < 3; c++) begin : g_mul
    logic signed [8:0] diff;
    assign diff    = $signed({1'b0, to_c[c]}) - $signed({1'b0, from_c[c]});
    assign prod[c] = prod_t'(diff) * prod_t'(fade_s);
  end

  // Product stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= prod[c];
      end
      p0_pos_q <= shade_i.pos;
    end
  end

  // Final add stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.pos   <= p0_pos_q;
      p1_q.red   <= blend_fin(from_c[0], prod_q[0]);
      p1_q.green <= blend_fin(from_c[1], prod_q[1]);
      p1_q.blue  <= blend_fin(from_c[2], prod_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= valid_i;
      p1_v_q <= p0_v_q;
    end
  end

  // Output register with skid: a stalled result parks in the skid register.
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (out_free) begin
      out_v_q <= p1_v_q;
    end else if (p1_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= p1_q;
    end else begin
      skid_q <= p1_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign pix_o       = out_q;

endmodule

@@ sv/elliptical_radial_gradient_fill.sv @@
// ----------------------------------------------------------------------------
// elliptical_radial_gradient_fill: pixel shader for an elliptical gradient
// Turns a pixel offset inside a rectangle into an interpolated RGB color.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and returns one colored pixel per clock
// in the same order, unless held by back-pressure from m_axis_tready. An input
// transfer passes 17 stages of axis normalization (one fold stage plus one
// quotient bit per stage of the span divider), 19 stages for the radial
// distance (square, sum, and one root bit per stage), two blend stages and
// the output register on its way to the matching output. Span and color
// registers may only be written while no pixel is in flight. A span of zero
// behaves as one; offsets beyond the span give the edge color.
module elliptical_radial_gradient_fill (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [erg_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [erg_pkg::CfgDataBits-1:0] cfg_data_i,
  // Pixel position stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata fields from bit 0: col_offset, row_offset.
  input  logic [erg_pkg::InDataBits-1:0]  s_axis_tdata,
  // Shaded pixel stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata fields from bit 0: out_col, out_row, red, green, blue.
  output logic [erg_pkg::OutDataBits-1:0] m_axis_tdata
);

  erg_pkg::cfg_t   cfg;
  erg_pkg::pos_t   in_pos;
  erg_pkg::norm_t  norm;
  erg_pkg::shade_t shade;
  erg_pkg::pix_t   pix;
  logic            en;
  logic            norm_v;
  logic            shade_v;

  // Unpack the input transfer.
  assign in_pos.col = s_axis_tdata[erg_pkg::CoordBits-1:0];
  assign in_pos.row = s_axis_tdata[2*erg_pkg::CoordBits-1:erg_pkg::CoordBits];

  assign s_axis_tready = en;

  erg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  erg_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .pos_i   (in_pos),
    .valid_o (norm_v),
    .norm_o  (norm)
  );

  erg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_v),
    .norm_i  (norm),
    .valid_o (shade_v),
    .shade_o (shade)
  );

  erg_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (shade_v),
    .shade_i     (shade),
    .ready_o     (en),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .pix_o       (pix)
  );

  // Pack the output transfer, zero filled to whole bytes.
  assign m_axis_tdata = erg_pkg::OutDataBits'({pix.blue, pix.green, pix.red,
                                               pix.pos.row, pix.pos.col});

endmodule
